// ===== sv/mma_pkg.sv =====
package mma_pkg;

  localparam int ChannelWidth = 8;
  localparam int SampleWidth  = 12;
  localparam int SampleMax    = (1 << SampleWidth) - 1;

  typedef struct packed {
    logic busy;
    logic done;
  } mma_div_stat_t;

endpackage

// ===== sv/mma_if.sv =====
interface mma_in_if import mma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ChannelWidth-1:0] channel;
  logic [SampleWidth-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mma_out_if import mma_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] average;
  logic                   bypassed;

  modport source (output valid, output average, output bypassed, input ready);
  modport sink   (input valid, input average, input bypassed, output ready);
endinterface

// ===== sv/mma_sample_mem.sv =====
module mma_sample_mem import mma_pkg::*; #(
  parameter int Depth = 128,
  parameter int AddrWidth = 7
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [AddrWidth-1:0]   addr_i,
  input  logic [SampleWidth-1:0] wdata_i,
  output logic [SampleWidth-1:0] rdata_o
);

  logic [SampleWidth-1:0] mem [Depth];
  logic [SampleWidth-1:0] rdata_q;

  // read old word, write new word at the same address
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mma_chan_mem.sv =====
module mma_chan_mem import mma_pkg::*; #(
  parameter int Depth = 8,
  parameter int AddrWidth = 3,
  parameter int SumWidth = 16,
  parameter int PosWidth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AddrWidth-1:0] rd_addr_i,
  output logic [SumWidth-1:0]  rd_sum_o,
  output logic [PosWidth-1:0]  rd_pos_o,
  output logic                 rd_filled_o,
  input  logic                 wr_en_i,
  input  logic [AddrWidth-1:0] wr_addr_i,
  input  logic [SumWidth-1:0]  wr_sum_i,
  input  logic [PosWidth-1:0]  wr_pos_i,
  input  logic                 wr_filled_i
);

  localparam int EntryWidth = SumWidth + PosWidth + 1;

  logic [EntryWidth-1:0] mem [Depth];
  logic [EntryWidth-1:0] rd_q;
  logic [Depth-1:0]      valid_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_sum_i, wr_pos_i, wr_filled_i};
    end
  end

  // unwritten entry reads as reset state
  assign rd_sum_o    = rd_valid_q ? rd_q[EntryWidth-1 -: SumWidth] : '0;
  assign rd_pos_o    = rd_valid_q ? rd_q[PosWidth:1] : '0;
  assign rd_filled_o = rd_valid_q & rd_q[0];

endmodule

// ===== sv/mma_divider.sv =====
module mma_divider import mma_pkg::*; #(
  parameter int DividendWidth = 16,
  parameter int DivisorWidth = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DividendWidth-1:0] dividend_i,
  input  logic [DivisorWidth-1:0]  divisor_i,
  output logic [DividendWidth-1:0] quotient_o,
  output mma_div_stat_t            stat_o
);

  localparam int CntWidth = $clog2(DividendWidth + 1);

  logic [CntWidth-1:0]      cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic [DivisorWidth-1:0]  rem_q, rem_d;
  logic [DividendWidth-1:0] quo_q, quo_d;
  logic [DivisorWidth-1:0]  div_q, div_d;
  logic [DivisorWidth:0]    trial;
  logic                     fits;

  assign trial = {rem_q, quo_q[DividendWidth-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d = CntWidth'(DividendWidth);
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntWidth'(1));
      if (fits) begin
        rem_d = DivisorWidth'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[DivisorWidth-1:0];
      end
      quo_d = {quo_q[DividendWidth-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

// ===== sv/multichannel_moving_average_unit.sv =====
// Channel | Dir | Word fields               | Handshake
// in_i    | in  | channel[7:0], sample[11:0] | valid/ready
// out_o   | out | average[11:0], bypassed   | valid/ready
//
// Filtered word: S_RD_SMP, S_UPDATE and S_DIVIDE, then S_DONE; the divide is
// the bit-serial divider, one quotient bit per cycle. Bypassed word: from
// S_IDLE straight to S_DONE. One word is in flight; the output register holds a
// finished result while the next word is taken in.
// Reset is asynchronous; channel state reads as zero until first written.
// A stalled output holds the next result in the done state.
module multichannel_moving_average_unit import mma_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int WINDOW = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  mma_in_if.sink      in_i,
  mma_out_if.source   out_o
);

  localparam int ChanIdxWidth = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PosWidth     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CountWidth   = $clog2(WINDOW + 1);
  localparam int SumWidth     = $clog2(WINDOW * SampleMax + 1);
  localparam int StoreDepth   = CHANNELS * WINDOW;
  localparam int StoreAddrW   = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RD_SMP = 5'b00010,
    S_UPDATE = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [ChanIdxWidth-1:0] ch_q;
  logic [SampleWidth-1:0]  sample_q;
  logic                    bypass_q;
  logic                    out_valid_q, out_valid_d;
  logic [SampleWidth-1:0]  average_q;
  logic                    bypassed_q;

  logic                    in_accept;
  logic                    is_bypass;
  logic [SumWidth-1:0]     chan_sum;
  logic [PosWidth-1:0]     chan_pos;
  logic                    chan_filled;
  logic [SampleWidth-1:0]  old_sample;
  logic [StoreAddrW-1:0]   store_addr;
  logic [SumWidth-1:0]     sum_new;
  logic [CountWidth-1:0]   pos_inc;
  logic                    wrap;
  logic                    filled_new;
  logic [PosWidth-1:0]     pos_new;
  logic [CountWidth-1:0]   divisor;
  logic                    div_start;
  logic [SumWidth-1:0]     quotient;
  mma_div_stat_t           div_stat;
  logic                    out_load;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign is_bypass  = in_i.channel >= ChannelWidth'(CHANNELS);

  assign store_addr = StoreAddrW'(ch_q) * StoreAddrW'(WINDOW) + StoreAddrW'(chan_pos);

  assign sum_new    = chan_sum - (chan_filled ? SumWidth'(old_sample) : '0)
                      + SumWidth'(sample_q);
  assign pos_inc    = CountWidth'(chan_pos) + 1'b1;
  assign wrap       = (pos_inc == CountWidth'(WINDOW));
  assign filled_new = chan_filled | wrap;
  assign pos_new    = wrap ? '0 : pos_inc[PosWidth-1:0];
  assign divisor    = filled_new ? CountWidth'(WINDOW) : pos_inc;
  assign div_start  = (state_q == S_UPDATE) && !div_stat.busy;

  mma_chan_mem #(
    .Depth     (CHANNELS),
    .AddrWidth (ChanIdxWidth),
    .SumWidth  (SumWidth),
    .PosWidth  (PosWidth)
  ) u_chan_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_accept && !is_bypass),
    .rd_addr_i   (in_i.channel[ChanIdxWidth-1:0]),
    .rd_sum_o    (chan_sum),
    .rd_pos_o    (chan_pos),
    .rd_filled_o (chan_filled),
    .wr_en_i     (div_start),
    .wr_addr_i   (ch_q),
    .wr_sum_i    (sum_new),
    .wr_pos_i    (pos_new),
    .wr_filled_i (filled_new)
  );

  mma_sample_mem #(
    .Depth     (StoreDepth),
    .AddrWidth (StoreAddrW)
  ) u_sample_mem (
    .clk_i   (clk_i),
    .en_i    (state_q == S_RD_SMP),
    .addr_i  (store_addr),
    .wdata_i (sample_q),
    .rdata_o (old_sample)
  );

  mma_divider #(
    .DividendWidth (SumWidth),
    .DivisorWidth  (CountWidth)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = is_bypass ? S_DONE : S_RD_SMP;
        end
      end
      S_RD_SMP: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (!div_stat.busy) begin
          state_d = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q     <= in_i.channel[ChanIdxWidth-1:0];
      sample_q <= in_i.sample;
      bypass_q <= is_bypass;
    end
    if (out_load) begin
      average_q  <= bypass_q ? sample_q : quotient[SampleWidth-1:0];
      bypassed_q <= bypass_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.average  = average_q;
  assign out_o.bypassed = bypassed_q;

endmodule
